// ===== sv/wrr_pkg.sv =====
package wrr_pkg;

	// Field widths of one packet descriptor and one result.
	localparam int ID_W     = 31;
	localparam int HANDLE_W = 16;
	localparam int LEN_W    = 10;
	localparam int WS_W     = 3;

	// Stream data widths: fields packed from bit 0, padded to whole bytes.
	localparam int SLOT_W   = ID_W + HANDLE_W + LEN_W;
	localparam int TDATA_W  = ((SLOT_W + 7) / 8) * 8;
	localparam int PAD_W    = TDATA_W - SLOT_W;

	// Defaults for the top-level parameters.
	localparam int WINDOW_DEF      = 4;
	localparam int MAX_PAYLOAD_DEF = 512;

	// Window size after reset.
	localparam logic [WS_W-1:0] WS_RESET = 3'd4;

	// Result kinds.
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// One held packet; the id sits in the lowest bits.
	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     id;
	} slot_t;

	// One result before it is framed on the output stream.
	typedef struct packed {
		logic  kind;
		slot_t body;
	} result_t;

endpackage

// ===== sv/wrr_slots.sv =====
module wrr_slots #(
	parameter int WINDOW = wrr_pkg::WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] wr_idx,
	input  wrr_pkg::slot_t                        wr_data,
	input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_idx,
	input  logic [wrr_pkg::ID_W-1:0]              key,
	output wrr_pkg::slot_t                        rd_data,
	output logic                                  hit
);
	import wrr_pkg::*;

	// Window storage; entries are only read below the fill count.
	slot_t slot_q [WINDOW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_idx] <= wr_data;
		end
	end

	// The single id comparator shared by the duplicate scan and the delivery search.
	assign rd_data = slot_q[rd_idx];
	assign hit     = (rd_data.id == key);

endmodule

// ===== sv/windowed_reorder_receiver.sv =====
// Channel   Direction  Signals                           Contents
// s_        in         tvalid tready tdata tlast         packet descriptor, tlast = end of file
// m_        out        tvalid tready tdata tuser tlast   ack or in-order delivery, tlast = final
// cfg_      in         we wdata                          window size
//
// Each item is accepted, scanned against every held packet for duplicates, decided on,
// searched in id order for delivery when a delivery runs, and its final result released;
// the scan and the search share the single id comparator, and output stalls add to the time.
// Reset clears the sequencer, the fill count, the base and the window size (to 4).
// A stall on m_tready holds the sequencer only when a result must move to the output.
module windowed_reorder_receiver #(
	parameter int WINDOW      = wrr_pkg::WINDOW_DEF,
	parameter int MAX_PAYLOAD = wrr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wrr_pkg::WS_W-1:0]     cfg_wdata,  // window_size
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [wrr_pkg::TDATA_W-1:0]  s_tdata,    // packet_id, payload_handle, payload_length
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [wrr_pkg::TDATA_W-1:0]  m_tdata,    // out_id, out_handle, out_length
	output logic                         m_tuser,    // kind
	output logic                         m_tlast
);
	import wrr_pkg::*;

	localparam int CW = $clog2(WINDOW + 1);
	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DELIV = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t            state_q;
	logic [WS_W-1:0]   cfg_q;
	logic [CW-1:0]     held_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     j_q;
	logic [ID_W-1:0]   base_q;
	logic [ID_W-1:0]   want_q;
	logic              fresh_q;
	logic              m_valid_q;

	slot_t             item_q;
	logic              eof_q;
	result_t           pend_q;
	result_t           m_res_q;
	logic              m_last_q;

	slot_t             in_slot;
	slot_t             rd_data;
	logic              hit;
	logic [ID_W-1:0]   key;
	logic [CW-1:0]     ws_eff;
	logic [CW:0]       held_inc;
	logic              accept;
	logic              push_ok;
	logic              scan_end;
	logic              store;
	logic              deliver;
	logic              deliv_miss;
	logic              deliv_hit;
	logic              deliv_step;
	logic              deliv_done;
	logic              push_mid;
	logic              push_fin;

	// Input unpacking with the payload length clamped.
	always_comb begin
		in_slot.id     = s_tdata[ID_W-1:0];
		in_slot.handle = s_tdata[ID_W+HANDLE_W-1:ID_W];
		if (int'(s_tdata[SLOT_W-1:ID_W+HANDLE_W]) > MAX_PAYLOAD) begin
			in_slot.length = LEN_W'(MAX_PAYLOAD);
		end else begin
			in_slot.length = s_tdata[SLOT_W-1:ID_W+HANDLE_W];
		end
	end

	// Effective window size, saturated to the range 1 to WINDOW.
	always_comb begin
		priority if (cfg_q == '0) begin
			ws_eff = CW'(1);
		end else if (int'(cfg_q) > WINDOW) begin
			ws_eff = CW'(WINDOW);
		end else begin
			ws_eff = CW'(cfg_q);
		end
	end

	// Slot store with the shared comparator.
	assign key = (state_q == ST_SCAN) ? item_q.id : want_q;

	wrr_slots #(
		.WINDOW (WINDOW)
	) u_slots (
		.clk     (clk),
		.wr_en   (store),
		.wr_idx  (held_q[IW-1:0]),
		.wr_data (item_q),
		.rd_idx  (idx_q[IW-1:0]),
		.key     (key),
		.rd_data (rd_data),
		.hit     (hit)
	);

	// Sequencer decode.
	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign push_ok    = !m_valid_q || m_tready;
	assign held_inc   = {1'b0, held_q} + (CW+1)'(1);
	assign scan_end   = (state_q == ST_SCAN) && (idx_q == held_q);
	assign store      = scan_end && fresh_q && (int'(held_q) < WINDOW);
	assign deliver    = store && (eof_q || (held_inc >= {1'b0, ws_eff}));
	assign deliv_miss = (state_q == ST_DELIV) && (idx_q == cnt_q);
	assign deliv_hit  = (state_q == ST_DELIV) && (idx_q != cnt_q) && hit;
	assign push_mid   = deliv_hit && push_ok;
	assign deliv_step = deliv_miss || push_mid;
	assign deliv_done = deliv_step && (j_q == (cnt_q - CW'(1)));
	assign push_fin   = (state_q == ST_FLUSH) && push_ok;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cfg_q     <= WS_RESET;
			held_q    <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			j_q       <= '0;
			base_q    <= '0;
			fresh_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						fresh_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						if (deliver) begin
							state_q <= ST_DELIV;
							held_q  <= '0;
							cnt_q   <= held_inc[CW-1:0];
							idx_q   <= '0;
							j_q     <= '0;
						end else begin
							state_q <= ST_FLUSH;
							if (store) begin
								held_q <= held_inc[CW-1:0];
							end
						end
					end else begin
						idx_q <= idx_q + CW'(1);
						if (hit) begin
							fresh_q <= 1'b0;
						end
					end
				end
				ST_DELIV: begin
					if (deliv_step) begin
						idx_q <= '0;
						if (deliv_done) begin
							state_q <= ST_FLUSH;
							base_q  <= base_q + ID_W'(cnt_q);
						end else begin
							j_q <= j_q + CW'(1);
						end
					end else if (!deliv_hit) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_FLUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Output register handshake.
			if (push_mid || push_fin) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item, pending result and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q             <= in_slot;
			eof_q              <= s_tlast;
			pend_q.kind        <= KIND_ACK;
			pend_q.body.id     <= in_slot.id;
			pend_q.body.handle <= '0;
			pend_q.body.length <= '0;
		end
		if (deliver) begin
			want_q <= base_q;
		end else if (deliv_step) begin
			want_q <= want_q + ID_W'(1);
		end
		if (push_mid) begin
			pend_q.kind <= KIND_DATA;
			pend_q.body <= rd_data;
		end
		if (push_mid || push_fin) begin
			m_res_q  <= pend_q;
			m_last_q <= push_fin;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_res_q.body};
	assign m_tuser  = m_res_q.kind;
	assign m_tlast  = m_last_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import wrr_pkg::*;

	localparam int NSLOT      = WINDOW_DEF;
	localparam int DRAIN      = 2 + NSLOT + NSLOT * (NSLOT + 1) + 10;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_PKTS = 36;

	// One packet descriptor waiting to be offered on the slave side.
	typedef struct packed {
		logic                eof;
		logic [LEN_W-1:0]    len;
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     id;
	} pkt_t;

	// One ack or delivery as it should appear on the master side.
	typedef struct packed {
		logic                kind;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
		logic                last;
	} reply_t;

	// Receive window contents, fill count, running base and window size.
	typedef struct packed {
		logic [NSLOT-1:0][ID_W-1:0]     id;
		logic [NSLOT-1:0][HANDLE_W-1:0] handle;
		logic [NSLOT-1:0][LEN_W-1:0]    len;
		logic [2:0]                     held;
		logic [ID_W-1:0]                base;
		logic [WS_W-1:0]                wsize;
	} window_state_t;

	// Window state after one packet, with the replies it causes.
	typedef struct packed {
		window_state_t     st;
		logic [2:0]        count;
		reply_t [NSLOT:0]  replies;
	} step_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [WS_W-1:0]      cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	pkt_t          tx_packets[$];
	reply_t        pending_replies[$];
	window_state_t plan_st;
	window_state_t model_st;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	logic          pkt_taken = 1'b0;
	int            mismatch_count = 0;
	int            pkts_accepted = 0;
	int            acks_seen = 0;
	int            deliveries_seen = 0;
	int            quiet_cycles = 0;

	windowed_reorder_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Register values 0 and above the window depth saturate.
	function automatic int eff_window(logic [WS_W-1:0] ws);
		if (ws < 1)
			return 1;
		if (ws > NSLOT)
			return NSLOT;
		return int'(ws);
	endfunction

	function automatic logic is_held(window_state_t s, logic [ID_W-1:0] id);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NSLOT; i++)
			if (i < s.held && s.id[i] == id)
				hit = 1'b1;
		return hit;
	endfunction

	// Acks the packet, stores it if new, and delivers in id order from the
	// base once the window is full or a new packet carries end of file.
	function automatic step_out_t reorder_step(window_state_t s, pkt_t p);
		step_out_t        o;
		logic             deliver;
		logic             found;
		logic [ID_W-1:0]  want;
		logic [LEN_W-1:0] len;
		int               cnt;
		int               n;
		o = '0;
		o.st = s;
		deliver = 1'b0;
		len = (p.len > MAX_PAYLOAD_DEF) ? LEN_W'(MAX_PAYLOAD_DEF) : p.len;
		o.replies[0].kind = KIND_ACK;
		o.replies[0].id = p.id;
		o.replies[0].last = 1'b1;
		n = 1;
		if (!is_held(s, p.id) && s.held < NSLOT) begin
			o.st.id[s.held] = p.id;
			o.st.handle[s.held] = p.handle;
			o.st.len[s.held] = len;
			o.st.held = s.held + 3'd1;
			deliver = p.eof || (o.st.held >= eff_window(s.wsize));
		end
		if (deliver) begin
			cnt = int'(o.st.held);
			for (int j = 0; j < cnt; j++) begin
				want = s.base + ID_W'(j);
				found = 1'b0;
				for (int i = 0; i < cnt; i++) begin
					if (!found && o.st.id[i] == want) begin
						o.replies[n-1].last = 1'b0;
						o.replies[n].kind = KIND_DATA;
						o.replies[n].id = want;
						o.replies[n].handle = o.st.handle[i];
						o.replies[n].len = o.st.len[i];
						o.replies[n].last = 1'b1;
						n++;
						found = 1'b1;
					end
				end
			end
			o.st.base = s.base + ID_W'(cnt);
			o.st.held = '0;
		end
		o.count = 3'(n);
		return o;
	endfunction

	// Queues one packet and tracks the window it will see once accepted.
	task automatic queue_packet(logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle,
			logic [LEN_W-1:0] len, logic eof);
		pkt_t      p;
		step_out_t o;
		p.id = id;
		p.handle = handle;
		p.len = len;
		p.eof = eof;
		tx_packets.push_back(p);
		o = reorder_step(plan_st, p);
		plan_st = o.st;
	endtask

	// Mostly fresh ids inside the window, with duplicates, ids just outside
	// the delivery range and fully random ids mixed in.
	task automatic queue_random(int npkts);
		int               pick;
		int               ws;
		int               sel;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		for (int k = 0; k < npkts; k++) begin
			ws = eff_window(plan_st.wsize);
			pick = $urandom_range(99);
			if (pick < 65) begin
				id = plan_st.base + ID_W'($urandom_range(ws - 1));
				repeat (8)
					if (is_held(plan_st, id))
						id = plan_st.base + ID_W'($urandom_range(ws - 1));
			end else if (pick < 75 && plan_st.held != 0) begin
				id = plan_st.id[$urandom_range(plan_st.held - 1)];
			end else if (pick < 88) begin
				if ($urandom_range(1))
					id = plan_st.base + ID_W'(ws) + ID_W'($urandom_range(6));
				else
					id = plan_st.base - ID_W'(1 + $urandom_range(3));
			end else begin
				id = ID_W'($urandom);
			end
			sel = $urandom_range(9);
			if (sel == 0)
				len = '0;
			else if (sel == 1)
				len = LEN_W'(MAX_PAYLOAD_DEF);
			else if (sel == 2)
				len = LEN_W'($urandom_range(1023, MAX_PAYLOAD_DEF + 1));
			else
				len = LEN_W'($urandom_range(MAX_PAYLOAD_DEF));
			queue_packet(id, HANDLE_W'($urandom_range(16'hFFFF)), len,
				$urandom_range(99) < 12);
		end
	endtask

	// Blocks until every queued packet is in and every reply has come out.
	task automatic wait_drained();
		while (tx_packets.size() != 0 || s_tvalid || pending_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_window(logic [WS_W-1:0] ws);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ws;
		@(negedge clk);
		cfg_we <= 1'b0;
		plan_st.wsize = ws;
		model_st.wsize = ws;
	endtask

	// Stimulus: directed corner cases, then random phases with varied idling.
	initial begin
		plan_st = '0;
		plan_st.wsize = WS_RESET;
		model_st = plan_st;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Field extremes, a duplicate carrying end of file, an oversized
		// length, an id beyond the range and a covered id that never came.
		queue_packet(31'd2, 16'hFFFF, 10'd0, 1'b0);
		queue_packet(31'd0, 16'h0000, 10'd512, 1'b0);
		queue_packet(31'd2, 16'h5555, 10'd7, 1'b1);
		queue_packet(31'h7FFF_FFFF, 16'h1234, 10'd1023, 1'b0);
		queue_packet(31'd1, 16'hAAAA, 10'd513, 1'b0);
		// End of file on a packet above the base, then the same id once more.
		queue_packet(31'd5, 16'h0F0F, 10'd100, 1'b1);
		queue_packet(31'd5, 16'hF0F0, 10'd200, 1'b0);
		// Shrink the window while a packet is held.
		set_window(3'd1);
		queue_packet(31'd6, 16'h0001, 10'd1, 1'b0);
		queue_packet(31'd7, 16'h8000, 10'd511, 1'b0);
		set_window(3'd0);
		queue_packet(31'd8, 16'h7FFF, 10'd256, 1'b0);
		set_window(3'd7);
		queue_packet(31'd11, 16'h0011, 10'd11, 1'b0);
		queue_packet(31'd10, 16'h0010, 10'd10, 1'b0);
		queue_packet(31'd9, 16'h0009, 10'd9, 1'b0);
		queue_packet(31'd12, 16'h0012, 10'd12, 1'b0);
		set_window(3'd3);
		queue_packet(31'd13, 16'h0013, 10'd13, 1'b1);
		queue_packet(31'd16, 16'h0016, 10'd16, 1'b0);
		queue_packet(31'd14, 16'h0014, 10'd14, 1'b0);
		queue_packet(31'd15, 16'h0015, 10'd15, 1'b0);

		set_window(3'd2);
		queue_random(PHASE_PKTS);
		set_window(3'd4);
		send_idle_pct = 58;
		queue_random(PHASE_PKTS);
		set_window(WS_W'($urandom_range(7)));
		send_idle_pct = 0;
		stall_pct = 58;
		queue_random(PHASE_PKTS);
		set_window(WS_W'($urandom_range(7)));
		send_idle_pct = 7;
		stall_pct = 7;
		queue_random(PHASE_PKTS);
		wait_drained();

		$display("Checked %0d packet descriptors over several window sizes, with and without",
			pkts_accepted);
		$display("source gaps and sink back-pressure: %0d acks, %0d in-order deliveries.",
			acks_seen, deliveries_seen);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Driver: offers the next request when the slot is free, with random gaps.
	always @(negedge clk) begin : drive
		pkt_t p;
		if (arst_n) begin
			if (!s_tvalid || pkt_taken) begin
				if (tx_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					p = tx_packets.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= TDATA_W'({p.len, p.handle, p.id});
					s_tlast <= p.eof;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predicts on each accepted packet, then checks each reply.
	always @(posedge clk) begin : monitor
		pkt_t      p;
		step_out_t o;
		reply_t    got;
		reply_t    want;
		pkt_taken = s_tvalid && s_tready;
		if (pkt_taken) begin
			p.id = s_tdata[0 +: ID_W];
			p.handle = s_tdata[ID_W +: HANDLE_W];
			p.len = s_tdata[ID_W + HANDLE_W +: LEN_W];
			p.eof = s_tlast;
			o = reorder_step(model_st, p);
			model_st = o.st;
			for (int i = 0; i < o.count; i++)
				pending_replies.push_back(o.replies[i]);
			pkts_accepted++;
		end
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.id = m_tdata[0 +: ID_W];
			got.handle = m_tdata[ID_W +: HANDLE_W];
			got.len = m_tdata[ID_W + HANDLE_W +: LEN_W];
			got.last = m_tlast;
			if (got.kind == KIND_DATA)
				deliveries_seen++;
			else
				acks_seen++;
			if (pending_replies.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected reply kind=%0d id=%0d handle=%0d len=%0d last=%0d",
						$realtime, got.kind, got.id, got.handle, got.len, got.last);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got.kind !== want.kind || got.id !== want.id ||
						got.handle !== want.handle || got.len !== want.len ||
						got.last !== want.last) begin
					if (mismatch_count < 10) begin
						$display("%0t: reply mismatch", $realtime);
						$display("  expected kind=%0d id=%0d handle=%0d len=%0d last=%0d",
							want.kind, want.id, want.handle, want.len, want.last);
						$display("  actual   kind=%0d id=%0d handle=%0d len=%0d last=%0d",
							got.kind, got.id, got.handle, got.len, got.last);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither side has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: %0d replies still outstanding.", pending_replies.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
